// ===== hw/rtl/pga_pkg.sv =====
// Shared constants and item types for the pairwise gravity acceleration block.
// No dependencies; every other file in hw/rtl imports this package.
package pga_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int MASS_WIDTH = 24;
    localparam int G_WIDTH    = 32;
    localparam int ACC_WIDTH  = 32;
    localparam int MUL_CHUNK  = 8;

    localparam logic [G_WIDTH-1:0]   G_RESET = 32'h0001_0000;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = 32'h7FFF_FFFF;
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] attractor_x;
        logic signed [POS_WIDTH-1:0] attractor_y;
        logic signed [POS_WIDTH-1:0] body_x;
        logic signed [POS_WIDTH-1:0] body_y;
        logic [MASS_WIDTH-1:0]       attractor_mass;
    } pga_in_t;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] accel_x;
        logic signed [ACC_WIDTH-1:0] accel_y;
        logic                        coincident;
        logic                        saturated;
    } pga_out_t;

endpackage

// ===== hw/rtl/pga_mul.sv =====
// Pipelined unsigned multiplier: one chunk of the b operand per stage, shift and add.
// Depends on pga_pkg for the default chunk width.
module pga_mul #(
    parameter int AW = 8,
    parameter int BW = 8,
    parameter int CH = pga_pkg::MUL_CHUNK
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    import pga_pkg::*;

    localparam int NS  = (BW + CH - 1) / CH;
    localparam int BPW = NS * CH;
    localparam int PW  = AW + BW;
    localparam int PPW = AW + CH;

    logic [AW-1:0]  a_reg   [NS];
    logic [BPW-1:0] b_reg   [NS];
    logic [PW-1:0]  acc_reg [NS];
    logic [PPW-1:0] pp      [NS];
    logic [BPW-1:0] b_pad;

    assign b_pad = BPW'(b);

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign pp[k] = PPW'(a) * PPW'(b_pad[CH-1:0]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k]   <= a;
                    b_reg[k]   <= b_pad;
                    acc_reg[k] <= PW'(pp[k]);
                end
            end
        end else begin : g_rest
            assign pp[k] = PPW'(a_reg[k-1]) * PPW'(b_reg[k-1][k*CH +: CH]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k]   <= a_reg[k-1];
                    b_reg[k]   <= b_reg[k-1];
                    acc_reg[k] <= acc_reg[k-1] + (PW'(pp[k]) << (k * CH));
                end
            end
        end
    end

    assign p = acc_reg[NS-1];

endmodule

// ===== hw/rtl/pga_delay.sv =====
// Enabled delay line that keeps side data aligned with the multiplier stages.
// Depends on pga_pkg only by convention; the contents are cleared at reset.
module pga_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    import pga_pkg::*;

    if (DEPTH == 0) begin : g_none
        assign q = d;
    end else begin : g_line
        logic [W-1:0] dl_reg [DEPTH];
        for (genvar k = 0; k < DEPTH; k++) begin : g_tap
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dl_reg[k] <= '0;
                else if (en)
                    dl_reg[k] <= (k == 0) ? d : dl_reg[(k == 0) ? 0 : k - 1];
            end
        end
        assign q = dl_reg[DEPTH-1];
    end

endmodule

// ===== hw/rtl/pairwise_gravity_acceleration.sv =====
// Pipeline: differences, magnitudes, squares, sum of squares, the bit-per-stage square root,
// the products, divider setup, the 32-stage restoring divider and the output register.
// Throughput: one item per cycle; the whole pipeline advances whenever the output register
// is empty or its item is being taken, so a stall freezes every stage in place.
// Reset (rst_n, asynchronous, active low) clears all valid bits and loads g = 1.0 (Q16.16).
// Depends on pga_pkg, pga_mul and pga_delay.
module pairwise_gravity_acceleration (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pair_valid,
    output logic                 pair_ready,
    input  pga_pkg::pga_in_t     pair,
    output logic                 accel_valid,
    input  logic                 accel_ready,
    output pga_pkg::pga_out_t    accel,
    input  logic                 cfg_we,
    input  logic [pga_pkg::G_WIDTH-1:0] cfg_data
);
    import pga_pkg::*;

    // Word widths of the exact integer datapath.
    localparam int P      = POS_WIDTH;
    localparam int DIFF_W = P + 1;
    localparam int MAG_W  = P;
    localparam int GM_W   = G_WIDTH + MASS_WIDTH;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int S_W    = SQ_W + 1;
    localparam int T_W0   = S_W + 32;
    localparam int R_W    = (T_W0 + 1) / 2;
    localparam int T_W    = 2 * R_W;
    localparam int REM_W  = R_W + 3;
    localparam int DEN_W  = S_W + R_W;
    localparam int NUM_W  = GM_W + MAG_W;
    localparam int CMP_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int QW     = ACC_WIDTH;
    localparam int L_NUM  = (MAG_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int L_DEN  = (R_W + MUL_CHUNK - 1) / MUL_CHUNK;

    typedef struct packed {
        logic              coin;
        logic              nx;
        logic              ny;
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
        logic [GM_W-1:0]   gm;
    } sq_side_t;

    typedef struct packed {
        logic coin;
        logic nx;
        logic ny;
    } fl_t;

    typedef struct packed {
        logic coin;
        logic nx;
        logic ny;
        logic bigx;
        logic bigy;
    } dv_side_t;

    // The whole pipeline moves together; the output register is the last stage.
    logic adv;
    logic accel_vld_reg;
    pga_out_t accel_reg;

    assign adv        = !accel_vld_reg || accel_ready;
    assign pair_ready = adv;
    assign accel_valid = accel_vld_reg;
    assign accel      = accel_reg;

    // Gravitational constant register.
    logic [G_WIDTH-1:0] gc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gc_reg <= G_RESET;
        else if (cfg_we)
            gc_reg <= cfg_data;
    end

    // Stage 1: position differences at full precision.
    logic                  dif_vld_reg;
    logic [DIFF_W-1:0]     dif_x_reg, dif_y_reg;
    logic [MASS_WIDTH-1:0] dif_mass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dif_vld_reg <= 1'b0;
        else if (adv)
            dif_vld_reg <= pair_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dif_x_reg    <= {pair.attractor_x[P-1], pair.attractor_x}
                          - {pair.body_x[P-1], pair.body_x};
            dif_y_reg    <= {pair.attractor_y[P-1], pair.attractor_y}
                          - {pair.body_y[P-1], pair.body_y};
            dif_mass_reg <= pair.attractor_mass;
        end
    end

    // Stage 2: magnitudes and signs, the coincidence test, and g*m.
    logic              mag_vld_reg;
    sq_side_t          mag_reg;
    logic [DIFF_W-1:0] neg_x, neg_y;

    assign neg_x = DIFF_W'(0) - dif_x_reg;
    assign neg_y = DIFF_W'(0) - dif_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mag_vld_reg <= 1'b0;
        else if (adv)
            mag_vld_reg <= dif_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg.nx   <= dif_x_reg[DIFF_W-1];
            mag_reg.ny   <= dif_y_reg[DIFF_W-1];
            mag_reg.ax   <= dif_x_reg[DIFF_W-1] ? neg_x[MAG_W-1:0] : dif_x_reg[MAG_W-1:0];
            mag_reg.ay   <= dif_y_reg[DIFF_W-1] ? neg_y[MAG_W-1:0] : dif_y_reg[MAG_W-1:0];
            mag_reg.coin <= (dif_x_reg == '0) && (dif_y_reg == '0);
            mag_reg.gm   <= GM_W'(gc_reg) * GM_W'(dif_mass_reg);
        end
    end

    // Squares of the two components, side data delayed alongside.
    logic [SQ_W-1:0] sqx, sqy;
    logic            sq_vld;
    sq_side_t        sq_side;

    pga_mul #(.AW(MAG_W), .BW(MAG_W)) u_sqx (
        .clk (clk), .en (adv), .a (mag_reg.ax), .b (mag_reg.ax), .p (sqx)
    );

    pga_mul #(.AW(MAG_W), .BW(MAG_W)) u_sqy (
        .clk (clk), .en (adv), .a (mag_reg.ay), .b (mag_reg.ay), .p (sqy)
    );

    pga_delay #(.W(1 + $bits(sq_side_t)), .DEPTH(L_NUM)) u_sq_dly (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .d   ({mag_vld_reg, mag_reg}),
        .q   ({sq_vld, sq_side})
    );

    // Sum of squares.
    logic           sum_vld_reg;
    sq_side_t       sum_side_reg;
    logic [S_W-1:0] sum_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_vld_reg <= 1'b0;
        else if (adv)
            sum_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_side_reg <= sq_side;
            sum_s_reg    <= S_W'(sqx) + S_W'(sqy);
        end
    end

    // Square root of S * 2^32, one result bit per stage (digit-by-digit method).
    logic             rt_vld_reg  [R_W];
    sq_side_t         rt_side_reg [R_W];
    logic [S_W-1:0]   rt_s_reg    [R_W];
    logic [T_W-1:0]   rt_t_reg    [R_W];
    logic [REM_W-1:0] rt_rem_reg  [R_W];
    logic [R_W-1:0]   rt_root_reg [R_W];

    for (genvar i = 0; i < R_W; i++) begin : g_rt
        logic             vld_in;
        sq_side_t         side_in;
        logic [S_W-1:0]   s_in;
        logic [T_W-1:0]   t_in;
        logic [REM_W-1:0] rem_in, rs, trial;
        logic [R_W-1:0]   root_in;
        logic             ge;

        if (i == 0) begin : g_first
            assign vld_in  = sum_vld_reg;
            assign side_in = sum_side_reg;
            assign s_in    = sum_s_reg;
            assign t_in    = T_W'({sum_s_reg, 32'h0});
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign vld_in  = rt_vld_reg[i-1];
            assign side_in = rt_side_reg[i-1];
            assign s_in    = rt_s_reg[i-1];
            assign t_in    = rt_t_reg[i-1];
            assign rem_in  = rt_rem_reg[i-1];
            assign root_in = rt_root_reg[i-1];
        end

        assign rs    = {rem_in[REM_W-3:0], t_in[T_W-1 -: 2]};
        assign trial = REM_W'({root_in, 2'b01});
        assign ge    = rs >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_vld_reg[i] <= 1'b0;
            else if (adv)
                rt_vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_side_reg[i] <= side_in;
                rt_s_reg[i]    <= s_in;
                rt_t_reg[i]    <= t_in << 2;
                rt_rem_reg[i]  <= ge ? rs - trial : rs;
                rt_root_reg[i] <= {root_in[R_W-2:0], ge};
            end
        end
    end

    // Denominator S*r and the numerators g*m*|d| (the 2^32 scale is folded into the divider).
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] numx_raw, numy_raw, numx, numy;
    logic             mul_vld;
    fl_t              mul_fl, rt_fl;

    assign rt_fl = '{coin: rt_side_reg[R_W-1].coin,
                     nx:   rt_side_reg[R_W-1].nx,
                     ny:   rt_side_reg[R_W-1].ny};

    pga_mul #(.AW(S_W), .BW(R_W)) u_den (
        .clk (clk), .en (adv), .a (rt_s_reg[R_W-1]), .b (rt_root_reg[R_W-1]), .p (den)
    );

    pga_mul #(.AW(GM_W), .BW(MAG_W)) u_numx (
        .clk (clk), .en (adv), .a (rt_side_reg[R_W-1].gm), .b (rt_side_reg[R_W-1].ax),
        .p (numx_raw)
    );

    pga_mul #(.AW(GM_W), .BW(MAG_W)) u_numy (
        .clk (clk), .en (adv), .a (rt_side_reg[R_W-1].gm), .b (rt_side_reg[R_W-1].ay),
        .p (numy_raw)
    );

    pga_delay #(.W(2 * NUM_W), .DEPTH(L_DEN - L_NUM)) u_num_dly (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .d   ({numx_raw, numy_raw}),
        .q   ({numx, numy})
    );

    pga_delay #(.W(1 + $bits(fl_t)), .DEPTH(L_DEN)) u_fl_dly (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .d   ({rt_vld_reg[R_W-1], rt_fl}),
        .q   ({mul_vld, mul_fl})
    );

    // Divider setup. The quotient exceeds 32 bits exactly when the numerator
    // reaches the denominator, so that compare is the overflow test and otherwise
    // the numerator is a valid starting remainder.
    logic             dv0_vld_reg;
    dv_side_t         dv0_side_reg;
    logic [DEN_W-1:0] dv0_den_reg, dv0_remx_reg, dv0_remy_reg;
    logic             bigx, bigy;

    assign bigx = CMP_W'(numx) >= CMP_W'(den);
    assign bigy = CMP_W'(numy) >= CMP_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv0_vld_reg <= 1'b0;
        else if (adv)
            dv0_vld_reg <= mul_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv0_side_reg <= '{coin: mul_fl.coin, nx: mul_fl.nx, ny: mul_fl.ny,
                              bigx: bigx, bigy: bigy};
            dv0_den_reg  <= den;
            dv0_remx_reg <= bigx ? '0 : DEN_W'(numx);
            dv0_remy_reg <= bigy ? '0 : DEN_W'(numy);
        end
    end

    // Restoring division, one quotient bit per stage for both components.
    logic             dv_vld_reg  [QW];
    dv_side_t         dv_side_reg [QW];
    logic [DEN_W-1:0] dv_den_reg  [QW];
    logic [DEN_W-1:0] dv_remx_reg [QW];
    logic [DEN_W-1:0] dv_remy_reg [QW];
    logic [QW-1:0]    dv_qx_reg   [QW];
    logic [QW-1:0]    dv_qy_reg   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_dv
        logic             vld_in;
        dv_side_t         side_in;
        logic [DEN_W-1:0] den_in, remx_in, remy_in;
        logic [QW-1:0]    qx_in, qy_in;
        logic [DEN_W:0]   rsx, rsy, den_ext;
        logic             gex, gey;

        if (i == 0) begin : g_first
            assign vld_in  = dv0_vld_reg;
            assign side_in = dv0_side_reg;
            assign den_in  = dv0_den_reg;
            assign remx_in = dv0_remx_reg;
            assign remy_in = dv0_remy_reg;
            assign qx_in   = '0;
            assign qy_in   = '0;
        end else begin : g_rest
            assign vld_in  = dv_vld_reg[i-1];
            assign side_in = dv_side_reg[i-1];
            assign den_in  = dv_den_reg[i-1];
            assign remx_in = dv_remx_reg[i-1];
            assign remy_in = dv_remy_reg[i-1];
            assign qx_in   = dv_qx_reg[i-1];
            assign qy_in   = dv_qy_reg[i-1];
        end

        assign den_ext = {1'b0, den_in};
        assign rsx     = {remx_in, 1'b0};
        assign rsy     = {remy_in, 1'b0};
        assign gex     = rsx >= den_ext;
        assign gey     = rsy >= den_ext;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[i] <= 1'b0;
            else if (adv)
                dv_vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_side_reg[i] <= side_in;
                dv_den_reg[i]  <= den_in;
                dv_remx_reg[i] <= DEN_W'(gex ? rsx - den_ext : rsx);
                dv_remy_reg[i] <= DEN_W'(gey ? rsy - den_ext : rsy);
                dv_qx_reg[i]   <= {qx_in[QW-2:0], gex};
                dv_qy_reg[i]   <= {qy_in[QW-2:0], gey};
            end
        end
    end

    // Sign, saturation and the coincident override, into the output register.
    // Returns {clipped, value}. A negative result may reach -2^31 without clipping.
    function automatic logic [QW:0] finish(input logic big, input logic neg,
                                           input logic [QW-1:0] q);
        logic clip;
        logic [QW-1:0] val;
        if (neg)
        begin
            clip = big || (q > ACC_MIN);
            val  = clip ? ACC_MIN : QW'(0) - q;
        end
        else
        begin
            clip = big || q[QW-1];
            val  = clip ? ACC_MAX : q;
        end
        return {clip, val};
    endfunction

    dv_side_t      fin_side;
    logic [QW:0]   fin_x, fin_y;

    assign fin_side = dv_side_reg[QW-1];
    assign fin_x    = finish(fin_side.bigx, fin_side.nx, dv_qx_reg[QW-1]);
    assign fin_y    = finish(fin_side.bigy, fin_side.ny, dv_qy_reg[QW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accel_vld_reg <= 1'b0;
        else if (adv)
            accel_vld_reg <= dv_vld_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (fin_side.coin)
            begin
                accel_reg.accel_x    <= '0;
                accel_reg.accel_y    <= '0;
                accel_reg.coincident <= 1'b1;
                accel_reg.saturated  <= 1'b0;
            end
            else
            begin
                accel_reg.accel_x    <= fin_x[QW-1:0];
                accel_reg.accel_y    <= fin_y[QW-1:0];
                accel_reg.coincident <= 1'b0;
                accel_reg.saturated  <= fin_x[QW] || fin_y[QW];
            end
        end
    end

    // A coincident item always leaves as an unflagged zero vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        accel_valid && accel.coincident |->
            accel.accel_x == '0 && accel.accel_y == '0 && !accel.saturated)
        else $error("coincident item with nonzero result");

    // A non-coincident item whose x quotient overflowed the divider must come out flagged.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && dv_vld_reg[QW-1] && fin_side.bigx && !fin_side.coin |=>
            accel_valid && accel.saturated)
        else $error("divider overflow not reported as saturation");

    // A flagged item carries at least one clipped component.
    assert property (@(posedge clk) disable iff (!rst_n)
        accel_valid && accel.saturated |->
            (accel.accel_x == ACC_MAX || accel.accel_x == ACC_MIN ||
             accel.accel_y == ACC_MAX || accel.accel_y == ACC_MIN))
        else $error("saturated item without a clipped component");

endmodule
